// ===== design/apsc_pkg.sv =====
package apsc_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;

	localparam int HDR_BYTES  = 8;
	localparam int BODY_BYTES = 18;

	localparam logic [4:0] BODY_LAST  = 5'd17;
	localparam logic [4:0] FRAME_LAST = 5'd27;
	localparam logic [4:0] CRC_HI_POS = 5'd8;
	localparam logic [4:0] CRC_LO_POS = 5'd9;

	localparam logic [7:0]  FRAME_LEN_BYTE = 8'd27;
	localparam logic [7:0]  TYPE_BYTE      = 8'hFF;
	localparam logic [7:0]  SEQ_RESET      = 8'hFD;
	localparam logic [39:0] HDR_RESET      = 40'h040857797A;

	localparam logic [31:0] LCG_MUL  = 32'd214013;
	localparam logic [31:0] LCG_INC  = 32'd2531011;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam logic [1:0] REG_HEADER_ID      = 2'd0;
	localparam logic [1:0] REG_OWN_MAC        = 2'd1;
	localparam logic [1:0] REG_REMOTE_COUNTER = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCRAMBLE,
		ST_EMIT
	} apsc_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} apsc_ctl_t;

endpackage

// ===== design/apsc_cmd_if.sv =====
interface apsc_cmd_if;
	logic        valid;
	logic        ready;
	logic [15:0] command;
	logic [7:0]  hop_limit;
	logic [63:0] payload;
	logic [3:0]  payload_len;
	logic [63:0] pad_bytes;

	modport source (
		output valid, command, hop_limit, payload, payload_len, pad_bytes,
		input  ready
	);
	modport sink (
		input  valid, command, hop_limit, payload, payload_len, pad_bytes,
		output ready
	);
endinterface

// ===== design/apsc_byte_if.sv =====
interface apsc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic [4:0] byte_index;
	logic       last;

	modport source (
		output valid, frame_byte, byte_index, last,
		input  ready
	);
	modport sink (
		input  valid, frame_byte, byte_index, last,
		output ready
	);
endinterface

// ===== design/apsc_cfg.sv =====
module apsc_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [apsc_pkg::ADDR_W-1:0] paddr,
	input  logic [apsc_pkg::DATA_W-1:0] pwdata,
	output logic [apsc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output logic [39:0]                header_id,
	output logic [47:0]                own_mac,
	output logic [1:0]                 remote_counter
);
	import apsc_pkg::*;

	logic [39:0] header_q;
	logic [47:0] mac_q;
	logic [1:0]  rc_q;
	logic [1:0]  idx;
	logic        wr;

	assign idx    = paddr[4:3];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HDR_RESET;
			mac_q    <= '0;
			rc_q     <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_HEADER_ID:      header_q <= pwdata[39:0];
				REG_OWN_MAC:        mac_q    <= pwdata[47:0];
				REG_REMOTE_COUNTER: rc_q     <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_HEADER_ID:      prdata = {24'h0, header_q};
			REG_OWN_MAC:        prdata = {16'h0, mac_q};
			REG_REMOTE_COUNTER: prdata = {62'h0, rc_q};
			default:            prdata = '0;
		endcase
	end

	assign header_id      = header_q;
	assign own_mac        = mac_q;
	assign remote_counter = rc_q;
endmodule

// ===== design/apsc_lcg.sv =====
module apsc_lcg (
	input  logic                clk,
	input  logic                arst_n,
	input  apsc_pkg::apsc_ctl_t ctl,
	input  logic [7:0]          seed,
	output logic [7:0]          key
);
	import apsc_pkg::*;

	logic [31:0] seed_q;
	logic [31:0] nxt;

	assign nxt = 32'(seed_q * LCG_MUL + LCG_INC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (ctl.load) begin
			seed_q <= {24'h0, seed};
		end else if (ctl.step) begin
			seed_q <= nxt;
		end
	end

	assign key = seed_q[23:16];
endmodule

// ===== design/apsc_crc.sv =====
module apsc_crc (
	input  logic                clk,
	input  logic                arst_n,
	input  apsc_pkg::apsc_ctl_t ctl,
	input  logic [7:0]          data,
	output logic [15:0]         crc
);
	import apsc_pkg::*;

	logic [15:0] crc_q;
	logic [15:0] nxt;

	// reflected shifts, byte folded into the low end
	always_comb begin
		nxt = crc_q ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (nxt[0]) begin
				nxt = (nxt >> 1) ^ CRC_POLY;
			end else begin
				nxt = nxt >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctl.load) begin
			crc_q <= CRC_INIT;
		end else if (ctl.step) begin
			crc_q <= nxt;
		end
	end

	assign crc = crc_q;
endmodule

// ===== design/adv_packet_scramble_crc_builder_unit.sv =====
// Advertising frame builder.
// cmd: one command transfer (command, hop_limit, payload, payload_len, pad_bytes)
//   is taken while the builder is idle; payload_len above 8 acts as 8.
// frm: the 28-byte frame leaves one byte per transfer with byte_index and
//   last, last set on byte 27.
// APB: header_id at 0x00, own_mac at 0x08, remote_counter at 0x10, 64-bit
//   data; write only between frames.
// Flow: after the command transfer, the scramble phase passes bytes 10..27 once
//   through the byte-wide scrambler and CRC (one byte per cycle, one LCG
//   multiply per cycle), then the emit phase sends the frame from the byte
//   shift registers.
// Stalls: frm.ready low holds the output register and freezes the sender;
//   cmd.ready stays low until the frame has been handed to the output register.
// Reset: sequence number 0xFD, registers to their defaults, no frame pending.
module adv_packet_scramble_crc_builder_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [apsc_pkg::ADDR_W-1:0] paddr,
	input  logic [apsc_pkg::DATA_W-1:0] pwdata,
	output logic [apsc_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	apsc_cmd_if.sink                    cmd,
	apsc_byte_if.source                 frm
);
	import apsc_pkg::*;

	apsc_state_t state_q, state_nxt;
	logic [4:0]  cnt_q;
	logic [7:0]  seq_q;
	logic [7:0]  hdr_q  [HDR_BYTES];
	logic [7:0]  body_q [BODY_BYTES];

	logic        out_v_q;
	logic [7:0]  out_byte_q;
	logic [4:0]  out_idx_q;
	logic        out_last_q;

	logic [39:0] header_id;
	logic [47:0] own_mac;
	logic [1:0]  remote_counter;
	logic [7:0]  key;
	logic [15:0] crc;
	logic [7:0]  scr_byte;
	logic [7:0]  emit_byte;

	logic        take;
	logic        scr;
	logic        emit;
	apsc_ctl_t   lcg_ctl;
	apsc_ctl_t   crc_ctl;

	apsc_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.header_id      (header_id),
		.own_mac        (own_mac),
		.remote_counter (remote_counter)
	);

	apsc_lcg u_lcg (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lcg_ctl),
		.seed   (seq_q),
		.key    (key)
	);

	apsc_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.data   (scr_byte),
		.crc    (crc)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:     if (cmd.valid) state_nxt = ST_SCRAMBLE;
			ST_SCRAMBLE: if (cnt_q == BODY_LAST) state_nxt = ST_EMIT;
			ST_EMIT:     if (emit && cnt_q == FRAME_LAST) state_nxt = ST_IDLE;
			default:     state_nxt = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		cmd.ready = (state_q == ST_IDLE);
		take      = (state_q == ST_IDLE) && cmd.valid;
		scr       = (state_q == ST_SCRAMBLE);
		emit      = (state_q == ST_EMIT) && (!out_v_q || frm.ready);
		lcg_ctl   = '{load: take, step: scr};
		crc_ctl   = '{load: take, step: scr};
	end

	// byte 10 (sequence) goes into the CRC unscrambled
	assign scr_byte = (cnt_q == 5'd0) ? body_q[0] : (body_q[0] ^ key);

	always_comb begin
		priority if (cnt_q < 5'(HDR_BYTES)) begin
			emit_byte = hdr_q[0];
		end else if (cnt_q == CRC_HI_POS) begin
			emit_byte = crc[15:8];
		end else if (cnt_q == CRC_LO_POS) begin
			emit_byte = crc[7:0];
		end else begin
			emit_byte = body_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			seq_q   <= SEQ_RESET;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (take) begin
				cnt_q <= '0;
			end else if (scr) begin
				cnt_q <= (cnt_q == BODY_LAST) ? 5'd0 : cnt_q + 5'd1;
			end else if (emit) begin
				cnt_q <= (cnt_q == FRAME_LAST) ? 5'd0 : cnt_q + 5'd1;
			end
			if (emit && cnt_q == FRAME_LAST) begin
				seq_q <= seq_q + 8'd1;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (frm.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			out_idx_q  <= cnt_q;
			out_last_q <= (cnt_q == FRAME_LAST);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			hdr_q[0] <= FRAME_LEN_BYTE;
			hdr_q[1] <= TYPE_BYTE;
			for (int k = 0; k < 5; k++) begin
				hdr_q[2+k] <= header_id[8*(4-k) +: 8];
			end
			hdr_q[7] <= cmd.hop_limit;
		end else if (emit && cnt_q < 5'(HDR_BYTES)) begin
			for (int k = 0; k < HDR_BYTES - 1; k++) begin
				hdr_q[k] <= hdr_q[k+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			body_q[0] <= seq_q;
			body_q[1] <= 8'h00;
			body_q[2] <= {remote_counter, own_mac[5:0]};
			for (int k = 1; k < 6; k++) begin
				body_q[2+k] <= own_mac[8*k +: 8];
			end
			body_q[8] <= cmd.command[15:8];
			body_q[9] <= cmd.command[7:0];
			for (int k = 0; k < 8; k++) begin
				body_q[10+k] <= (4'(k) < cmd.payload_len) ? cmd.payload[8*k +: 8]
				                                          : cmd.pad_bytes[8*k +: 8];
			end
		end else if (scr) begin
			for (int k = 0; k < BODY_BYTES - 1; k++) begin
				body_q[k] <= body_q[k+1];
			end
			body_q[BODY_BYTES-1] <= scr_byte;
		end else if (emit && cnt_q > CRC_LO_POS) begin
			for (int k = 0; k < BODY_BYTES - 1; k++) begin
				body_q[k] <= body_q[k+1];
			end
		end
	end

	assign frm.valid      = out_v_q;
	assign frm.frame_byte = out_byte_q;
	assign frm.byte_index = out_idx_q;
	assign frm.last       = out_last_q;
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import apsc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT = 28;
	localparam int FRAME_BYTES = 28;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic [15:0] command;
		logic [7:0]  hop_limit;
		logic [63:0] payload;
		logic [3:0]  payload_len;
		logic [63:0] pad_bytes;
	} cmd_item_t;

	typedef struct {
		logic [7:0] frame_byte;
		logic [4:0] byte_index;
		logic       last;
	} frame_byte_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	apsc_cmd_if cmd ();
	apsc_byte_if frm ();

	adv_packet_scramble_crc_builder_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cmd     (cmd.sink),
		.frm     (frm.source)
	);

	// builder state as seen by the predictor
	logic [39:0] header_id;
	logic [47:0] own_mac;
	logic [1:0]  remote_counter;
	logic [7:0]  seq_num;

	frame_byte_t frame_q[$];

	int  failures;
	int  cycles;
	int  cmds_sent;
	int  bytes_checked;
	int  reg_writes;
	int  seq_wraps;
	bit  idling;
	int  sink_hold;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// frame sink ready, with a countable hold-off
	initial frm.ready = 1'b0;
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			frm.ready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else if (idling) begin
			frm.ready <= ($urandom_range(99) >= IDLE_PCT);
		end else begin
			frm.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		frame_byte_t exp_b;
		if (frm.valid === 1'b1 && frm.ready === 1'b1) begin
			if (frame_q.size() == 0) begin
				$error("unexpected frame byte %02h at index %0d", frm.frame_byte, frm.byte_index);
				failures++;
			end else begin
				exp_b = frame_q.pop_front();
				bytes_checked++;
				if (frm.frame_byte !== exp_b.frame_byte) begin
					$error("frame_byte: expected %02h, got %02h (index %0d)",
						exp_b.frame_byte, frm.frame_byte, exp_b.byte_index);
					failures++;
				end
				if (frm.byte_index !== exp_b.byte_index) begin
					$error("byte_index: expected %0d, got %0d", exp_b.byte_index, frm.byte_index);
					failures++;
				end
				if (frm.last !== exp_b.last) begin
					$error("last: expected %0b, got %0b (index %0d)",
						exp_b.last, frm.last, exp_b.byte_index);
					failures++;
				end
			end
		end
	end

	function automatic void predict_frame(cmd_item_t c);
		logic [7:0]  f[FRAME_BYTES];
		logic [31:0] lcg;
		logic [15:0] crc;
		logic [3:0]  plen;
		frame_byte_t b;
		plen = (c.payload_len > 4'd8) ? 4'd8 : c.payload_len;
		f[0] = FRAME_LEN_BYTE;
		f[1] = TYPE_BYTE;
		for (int i = 0; i < 5; i++)
			f[2 + i] = header_id[8 * (4 - i) +: 8];
		f[7] = c.hop_limit;
		f[10] = seq_num;
		f[11] = 8'h00;
		for (int i = 0; i < 6; i++)
			f[12 + i] = own_mac[8 * i +: 8];
		f[12][7:6] = remote_counter;
		f[18] = c.command[15:8];
		f[19] = c.command[7:0];
		for (int i = 0; i < 8; i++)
			f[20 + i] = (i < plen) ? c.payload[8 * i +: 8] : c.pad_bytes[8 * i +: 8];
		lcg = {24'd0, seq_num};
		for (int i = 11; i < FRAME_BYTES; i++) begin
			lcg = LCG_MUL * lcg + LCG_INC;
			f[i] = f[i] ^ lcg[23:16];
		end
		crc = CRC_INIT;
		for (int i = 10; i < FRAME_BYTES; i++) begin
			crc[7:0] = crc[7:0] ^ f[i];
			for (int k = 0; k < 8; k++)
				crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
		end
		f[CRC_HI_POS] = crc[15:8];
		f[CRC_LO_POS] = crc[7:0];
		if (seq_num == 8'hFF)
			seq_wraps++;
		seq_num = seq_num + 8'd1;
		for (int i = 0; i < FRAME_BYTES; i++) begin
			b.frame_byte = f[i];
			b.byte_index = i[4:0];
			b.last = (i[4:0] == FRAME_LAST);
			frame_q.push_back(b);
		end
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic cmd_item_t rand_cmd();
		cmd_item_t c;
		c.command = 16'($urandom);
		c.hop_limit = 8'($urandom);
		c.payload = rand64();
		c.payload_len = 4'($urandom_range(15));
		c.pad_bytes = rand64();
		return c;
	endfunction

	function automatic cmd_item_t make_cmd(logic [15:0] command, logic [7:0] hop,
		logic [63:0] payload, logic [3:0] plen, logic [63:0] pad);
		cmd_item_t c;
		c.command = command;
		c.hop_limit = hop;
		c.payload = payload;
		c.payload_len = plen;
		c.pad_bytes = pad;
		return c;
	endfunction

	// valid stays high after a transfer unless an idle gap is drawn, so back-to-back commands need no extra edge
	task automatic send_command(cmd_item_t c);
		@(negedge clk);
		cmd.command <= c.command;
		cmd.hop_limit <= c.hop_limit;
		cmd.payload <= c.payload;
		cmd.payload_len <= c.payload_len;
		cmd.pad_bytes <= c.pad_bytes;
		cmd.valid <= 1'b1;
		do @(posedge clk); while (cmd.ready !== 1'b1);
		predict_frame(c);
		cmds_sent++;
		if (idling && $urandom_range(99) < IDLE_PCT) begin
			@(negedge clk);
			cmd.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic drain_frames();
		@(negedge clk);
		cmd.valid <= 1'b0;
		while (frame_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [63:0] value);
		logic [63:0] readback;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		reg_writes++;
		case (idx)
			REG_HEADER_ID: begin
				header_id = value[39:0];
				readback = {24'd0, header_id};
			end
			REG_OWN_MAC: begin
				own_mac = value[47:0];
				readback = {16'd0, own_mac};
			end
			REG_REMOTE_COUNTER: begin
				remote_counter = value[1:0];
				readback = {62'd0, remote_counter};
			end
			default: return;
		endcase
		@(negedge clk);
		psel <= 1'b1;
		paddr <= {idx, 3'b000};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== readback) begin
			$error("prdata: expected %016h, got %016h (register %0d)", readback, prdata, idx);
			failures++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_default_registers();
		send_command(make_cmd(16'h0000, 8'h00, 64'd0, 4'd0, 64'd0));
		send_command(make_cmd(16'hFFFF, 8'hFF, '1, 4'd15, '1));
		send_command(make_cmd(16'hFFFF, 8'h00, rand64(), 4'd8, rand64()));
		send_command(make_cmd(16'h0000, 8'hFF, rand64(), 4'd9, rand64()));
		send_command(make_cmd(16'($urandom), 8'($urandom), rand64(), 4'd0, rand64()));
		send_command(make_cmd(16'($urandom), 8'($urandom), '1, 4'd0, 64'd0));
		send_command(make_cmd(16'($urandom), 8'($urandom), 64'd0, 4'd8, '1));
		for (int n = 1; n < 8; n++)
			send_command(make_cmd(16'($urandom), 8'($urandom), rand64(), n[3:0], rand64()));
		drain_frames();
	endtask

	task automatic test_register_extremes();
		write_register(REG_HEADER_ID, '1);
		write_register(REG_OWN_MAC, '1);
		write_register(REG_REMOTE_COUNTER, '1);
		send_command(make_cmd(16'h0000, 8'h00, 64'd0, 4'd0, 64'd0));
		send_command(make_cmd(16'hFFFF, 8'hFF, '1, 4'd8, '1));
		drain_frames();
		write_register(REG_REMOTE_COUNTER, 64'd1);
		send_command(rand_cmd());
		drain_frames();
		write_register(REG_HEADER_ID, 64'd0);
		write_register(REG_OWN_MAC, 64'd0);
		write_register(REG_REMOTE_COUNTER, 64'd2);
		send_command(make_cmd(16'hFFFF, 8'h00, '1, 4'd15, 64'd0));
		drain_frames();
		// write to an unmapped slot must leave every register alone
		write_register(REG_UNUSED, '1);
		write_register(REG_REMOTE_COUNTER, 64'd0);
		send_command(rand_cmd());
		drain_frames();
	endtask

	task automatic test_random_traffic(int phases, int per_phase);
		for (int p = 0; p < phases; p++) begin
			write_register(REG_HEADER_ID, rand64());
			write_register(REG_OWN_MAC, rand64());
			write_register(REG_REMOTE_COUNTER, rand64());
			if ($urandom_range(3) == 0)
				write_register(REG_UNUSED, rand64());
			idling = (p != 1);
			for (int n = 0; n < per_phase; n++)
				send_command(rand_cmd());
			drain_frames();
		end
		idling = 1'b1;
	endtask

	task automatic test_sink_backpressure();
		@(posedge clk);
		sink_hold = 300;
		for (int n = 0; n < 6; n++)
			send_command(rand_cmd());
		drain_frames();
	endtask

	task automatic test_paused_source();
		for (int n = 0; n < 8; n++) begin
			send_command(rand_cmd());
			drain_frames();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd.valid = 1'b0;
		cmd.command = '0;
		cmd.hop_limit = '0;
		cmd.payload = '0;
		cmd.payload_len = '0;
		cmd.pad_bytes = '0;
		failures = 0;
		cycles = 0;
		cmds_sent = 0;
		bytes_checked = 0;
		reg_writes = 0;
		seq_wraps = 0;
		sink_hold = 0;
		idling = 1'b1;
		header_id = HDR_RESET;
		own_mac = '0;
		remote_counter = '0;
		seq_num = SEQ_RESET;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_default_registers();
		test_register_extremes();
		test_random_traffic(4, 72);
		test_sink_backpressure();
		test_paused_source();

		repeat (60) @(posedge clk);
		$display("Covered %0d commands, %0d frame bytes, %0d register writes, %0d sequence wraps.",
			cmds_sent, bytes_checked, reg_writes, seq_wraps);
		if (failures == 0 && frame_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
